// ----- hdl/tcac_pkg.sv -----
// tcac_pkg: shared constants, types and body-part tables for the taxel
// cluster activation counter. No dependencies.
`timescale 1ns / 1ps

package tcac_pkg;

  localparam int MAX_CLUSTERS = 64;
  localparam int CLUSTER_W    = $clog2(MAX_CLUSTERS);
  localparam int PATCH_TAXELS = 192;
  localparam int BODY_PARTS   = 7;
  localparam int MAP_DEPTH    = 3 * 4 * PATCH_TAXELS + 2 * 2 * PATCH_TAXELS
                                + 2 * PATCH_TAXELS;
  localparam int MAP_AW       = $clog2(MAP_DEPTH);
  localparam int TAXEL_W      = 10;
  localparam int PART_W       = 3;
  localparam int COUNT_W      = 12;
  localparam int NUM_W        = 7;
  localparam int DATA_W       = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] CMD_MAP   = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_FRAME = 2'd2;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_NUM_CLUSTERS = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic [CLUSTER_W-1:0] cluster;
  } map_entry_t;

  // request from the sequencer to the count bank
  typedef struct packed {
    logic                 rd_en;
    logic                 wr_en;
    logic                 clear;
    logic [CLUSTER_W-1:0] addr;
    logic [COUNT_W-1:0]   wr_data;
  } cnt_req_t;

  // taxels held by a body part; unknown parts hold none
  function automatic logic [TAXEL_W-1:0] part_size(input logic [PART_W-1:0] part);
    logic [TAXEL_W-1:0] size;
    unique case (part)
      3'd0, 3'd1, 3'd2: size = TAXEL_W'(4 * PATCH_TAXELS);
      3'd3, 3'd4:       size = TAXEL_W'(2 * PATCH_TAXELS);
      3'd5, 3'd6:       size = TAXEL_W'(PATCH_TAXELS);
      default:          size = '0;
    endcase
    return size;
  endfunction

  // first map address of a body part in the packed map
  function automatic logic [MAP_AW-1:0] part_base(input logic [PART_W-1:0] part);
    logic [MAP_AW-1:0] base;
    unique case (part)
      3'd0:    base = MAP_AW'(0);
      3'd1:    base = MAP_AW'(4 * PATCH_TAXELS);
      3'd2:    base = MAP_AW'(8 * PATCH_TAXELS);
      3'd3:    base = MAP_AW'(12 * PATCH_TAXELS);
      3'd4:    base = MAP_AW'(14 * PATCH_TAXELS);
      3'd5:    base = MAP_AW'(16 * PATCH_TAXELS);
      3'd6:    base = MAP_AW'(17 * PATCH_TAXELS);
      default: base = '0;
    endcase
    return base;
  endfunction

endpackage

// ----- hdl/tcac_count_bank.sv -----
// tcac_count_bank: per-cluster activation counts in a small memory with
// one valid bit per entry, so a frame end clears every count at once.
// Depends on tcac_pkg.
`timescale 1ns / 1ps

module tcac_count_bank import tcac_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cnt_req_t           req_i,
  output logic [COUNT_W-1:0] rd_data_o
);

  logic [COUNT_W-1:0]      cnt_mem [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] valid_q, valid_d;
  logic [COUNT_W-1:0]      rd_data_q;

  always_comb begin
    valid_d = valid_q;
    if (req_i.clear) begin
      valid_d = '0;
    end else if (req_i.wr_en) begin
      valid_d[req_i.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // an entry not written since the last clear reads as zero
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      cnt_mem[req_i.addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= valid_q[req_i.addr] ? cnt_mem[req_i.addr] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/taxel_cluster_activation_counter.sv -----
// taxel_cluster_activation_counter: top level, sequencer, taxel map memory.
// Depends on tcac_pkg and tcac_count_bank.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------------
//  command  | start_i / busy_o            | cmd, body_part, first/last_taxel, cluster_id,
//           |                             | sample_value
//  result   | res_valid_o (one-cycle beat)| cluster_index, activation_count, last
//  config   | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
// After reset the map is cleared one entry a cycle, with busy_o high until all
// 3456 entries (the map depth) are cleared; config writes are taken meanwhile.
// Per command: a map write writes one map entry per taxel in range; a sample in range
// reads its map entry and, if it counts, reads and then writes back its cluster's count;
// end of frame reports each cluster in turn, then clears the counts.
// Results cannot be stalled; each beat is valid for exactly one cycle.
`timescale 1ns / 1ps

module taxel_cluster_activation_counter import tcac_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              cmd_i,
  input  logic [PART_W-1:0]       body_part_i,
  input  logic [TAXEL_W-1:0]      first_taxel_i,
  input  logic [TAXEL_W-1:0]      last_taxel_i,
  input  logic signed [NUM_W-1:0] cluster_id_i,
  input  logic [DATA_W-1:0]       sample_value_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic                    cfg_index_i,
  input  logic [DATA_W-1:0]       cfg_data_i,
  output logic                    res_valid_o,
  output logic [CLUSTER_W-1:0]    cluster_index_o,
  output logic [COUNT_W-1:0]      activation_count_o,
  output logic                    last_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MAP   = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SCHK  = 4'd4;
  localparam logic [3:0] S_SCNT  = 4'd5;
  localparam logic [3:0] S_RRD   = 4'd6;
  localparam logic [3:0] S_REMIT = 4'd7;
  localparam logic [3:0] S_FLUSH = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]           state_q, state_d;
  logic [MAP_AW-1:0]    addr_q, addr_d;
  logic [MAP_AW-1:0]    end_q, end_d;
  map_entry_t           entry_q, entry_d;
  logic [DATA_W-1:0]    value_q, value_d;
  logic [CLUSTER_W-1:0] k_q, k_d;
  logic [NUM_W-1:0]     nlim_q, nlim_d;
  logic [DATA_W-1:0]    threshold_q;
  logic [NUM_W-1:0]     num_clusters_q;

  map_entry_t           map_mem [MAP_DEPTH];
  map_entry_t           map_rd_q;
  logic                 map_we, map_re;
  map_entry_t           map_wdata;

  cnt_req_t             cnt_req;
  logic [COUNT_W-1:0]   cnt_rd_data;

  logic [TAXEL_W-1:0]   size, lo, hi;
  logic [MAP_AW-1:0]    base;
  logic                 last_k;

  // ---------------- configuration registers ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= '0;
      num_clusters_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_THRESHOLD:    threshold_q    <= cfg_data_i;
        REG_NUM_CLUSTERS: num_clusters_q <= cfg_data_i[NUM_W-1:0];
        default:          ;
      endcase
    end
  end

  // ---------------- range clipping of the incoming command ----------------
  assign size = part_size(body_part_i);
  assign base = part_base(body_part_i);
  assign lo   = (first_taxel_i == '0) ? TAXEL_W'(1) : first_taxel_i;
  assign hi   = (last_taxel_i > size) ? size : last_taxel_i;

  assign last_k = ({1'b0, k_q} == nlim_q - NUM_W'(1));

  // ---------------- sequencer ----------------
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    end_d     = end_q;
    entry_d   = entry_q;
    value_d   = value_q;
    k_d       = k_q;
    nlim_d    = nlim_q;
    map_we    = 1'b0;
    map_re    = 1'b0;
    map_wdata = entry_q;
    cnt_req   = '0;

    unique case (state_q)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_wdata = '0;
        addr_d    = addr_q + MAP_AW'(1);
        if (addr_q == MAP_AW'(MAP_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          addr_d  = base + MAP_AW'(lo) - MAP_AW'(1);
          end_d   = base + MAP_AW'(hi) - MAP_AW'(1);
          value_d = sample_value_i;
          // negative cluster ids unmap the range
          entry_d.valid   = !cluster_id_i[NUM_W-1];
          entry_d.cluster = cluster_id_i[CLUSTER_W-1:0];
          k_d     = '0;
          nlim_d  = (num_clusters_q > NUM_W'(MAX_CLUSTERS)) ? NUM_W'(MAX_CLUSTERS)
                                                             : num_clusters_q;
          state_d = S_DONE;
          unique case (cmd_i)
            CMD_MAP: begin
              if (lo <= hi) begin
                state_d = S_MAP;
              end
            end
            CMD_SAMPLE: begin
              if (first_taxel_i != '0 && first_taxel_i <= size) begin
                state_d = S_SRD;
              end
            end
            CMD_FRAME: begin
              state_d = (nlim_d == '0) ? S_FLUSH : S_RRD;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_MAP: begin
        map_we = 1'b1;
        addr_d = addr_q + MAP_AW'(1);
        if (addr_q == end_q) begin
          state_d = S_IDLE;
        end
      end
      S_SRD: begin
        map_re  = 1'b1;
        state_d = S_SCHK;
      end
      S_SCHK: begin
        if (map_rd_q.valid && value_q > threshold_q) begin
          cnt_req.rd_en = 1'b1;
          cnt_req.addr  = map_rd_q.cluster;
          state_d       = S_SCNT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCNT: begin
        // saturate at the top of the count range
        cnt_req.addr    = map_rd_q.cluster;
        cnt_req.wr_en   = (cnt_rd_data != COUNT_MAX);
        cnt_req.wr_data = cnt_rd_data + COUNT_W'(1);
        state_d         = S_IDLE;
      end
      S_RRD: begin
        cnt_req.rd_en = 1'b1;
        cnt_req.addr  = k_q;
        state_d       = S_REMIT;
      end
      S_REMIT: begin
        if (last_k) begin
          state_d = S_FLUSH;
        end else begin
          k_d     = k_q + CLUSTER_W'(1);
          state_d = S_RRD;
        end
      end
      S_FLUSH: begin
        cnt_req.clear = 1'b1;
        state_d       = S_IDLE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      addr_q  <= '0;
      k_q     <= '0;
      nlim_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      k_q     <= k_d;
      nlim_q  <= nlim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q   <= end_d;
    entry_q <= entry_d;
    value_q <= value_d;
  end

  // ---------------- taxel map memory ----------------
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[addr_q] <= map_wdata;
    end
    if (map_re) begin
      map_rd_q <= map_mem[addr_q];
    end
  end

  tcac_count_bank u_count_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (cnt_req),
    .rd_data_o (cnt_rd_data)
  );

  // ---------------- outputs ----------------
  assign busy_o             = (state_q != S_IDLE);
  assign res_valid_o        = (state_q == S_REMIT);
  assign cluster_index_o    = k_q;
  assign activation_count_o = cnt_rd_data;
  assign last_o             = (state_q == S_REMIT) && last_k;

endmodule

// ----- hdl/tcac_checker.sv -----
// tcac_checker: port-level assertions for the taxel cluster activation
// counter, attached to the top level by bind. Depends on tcac_pkg.
`timescale 1ns / 1ps

module tcac_checker import tcac_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_o,
  input logic                 res_valid_o,
  input logic                 last_o,
  input logic [CLUSTER_W-1:0] cluster_index_o
);

  // an accepted command always makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("command accepted without going busy");

  a_beat_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy_o)
    else $error("result beat while idle");

  a_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> res_valid_o)
    else $error("last flag without a result beat");

  // report walks the clusters in order, one cluster per beat
  a_report_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |-> ##2
      (res_valid_o && cluster_index_o ==
       CLUSTER_W'($past(cluster_index_o, 2) + CLUSTER_W'(1))))
    else $error("frame report out of order");

endmodule

bind taxel_cluster_activation_counter tcac_checker u_tcac_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .res_valid_o     (res_valid_o),
  .last_o          (last_o),
  .cluster_index_o (cluster_index_o)
);
